// ===== hw/rtl/rbsi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// shared types and register indexes of the ray against box slab test
// ----------------------------------------------------------------------------
package rbsi_pkg;

  typedef logic [2:0] cfg_index_t;

  localparam cfg_index_t REG_BOX_MIN_X = 3'd0;
  localparam cfg_index_t REG_BOX_MIN_Y = 3'd1;
  localparam cfg_index_t REG_BOX_MIN_Z = 3'd2;
  localparam cfg_index_t REG_BOX_MAX_X = 3'd3;
  localparam cfg_index_t REG_BOX_MAX_Y = 3'd4;
  localparam cfg_index_t REG_BOX_MAX_Z = 3'd5;

  localparam int AXES = 3;

endpackage

// ===== hw/rtl/ray_box_slab_intersection_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersection_top
// ray against axis-aligned box, slab method, signed fixed point with saturation
// ----------------------------------------------------------------------------
// a request passes the capture stage, then the reciprocal divider, one quotient bit
//   per pipeline stage over 2*FRACTION_BITS + 1 stages, then six arithmetic stages;
//   FRACTION_BITS is 16 by default, giving Q16.16 coordinates
// throughput: one ray per cycle while out_stall does not hold a valid result,
//   requests may follow back to back; the whole pipeline advances unless a valid result is held by out_stall
// reset clears every valid bit and the six box registers to zero
module ray_box_slab_intersection_top #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // ray requests
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] origin_z,
  input  logic signed [COORD_WIDTH-1:0] direction_x,
  input  logic signed [COORD_WIDTH-1:0] direction_y,
  input  logic signed [COORD_WIDTH-1:0] direction_z,
  input  logic signed [COORD_WIDTH-1:0] interval_start,
  input  logic signed [COORD_WIDTH-1:0] interval_end,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic signed [COORD_WIDTH-1:0] entry_distance,
  output logic signed [COORD_WIDTH-1:0] exit_distance,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y,
  output logic signed [COORD_WIDTH-1:0] point_z,
  // box corner writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  rbsi_pkg::cfg_index_t          cfg_index,
  input  logic        [COORD_WIDTH-1:0] cfg_data
);
  import rbsi_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int QW = 2 * F + 1;          // quotient bits of 2^(2F) / |d|
  localparam int DW = W + 1;              // partial remainder width
  localparam int XW = (QW > W) ? QW : W;  // width for the reciprocal clamp
  localparam int PW = 2 * W + 1;          // plane distance product width
  localparam int EW = 2 * W;              // entry point product width

  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  // shift right by the fraction, clamp the magnitude, apply the sign
  function automatic logic signed [W-1:0] fix_scale(input logic [PW-1:0] m,
                                                    input logic neg);
    logic [PW-1:0] q;
    logic [PW-1:0] lim;
    q   = m >> F;
    lim = neg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
    if (q > lim) q = lim;
    if (neg) q = ~q + PW'(1);
    return q[W-1:0];
  endfunction

  // global advance: everything moves unless the output is held
  logic en;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // box corners
  logic signed [W-1:0] box_lo [AXES];
  logic signed [W-1:0] box_hi [AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        box_lo[a] <= '0;
        box_hi[a] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BOX_MIN_X: box_lo[0] <= cfg_data;
        REG_BOX_MIN_Y: box_lo[1] <= cfg_data;
        REG_BOX_MIN_Z: box_lo[2] <= cfg_data;
        REG_BOX_MAX_X: box_hi[0] <= cfg_data;
        REG_BOX_MAX_Y: box_hi[1] <= cfg_data;
        REG_BOX_MAX_Z: box_hi[2] <= cfg_data;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // capture stage and reciprocal divider chain (index 0 is the capture stage)
  // --------------------------------------------------------------------------
  logic                dv   [QW+1];
  logic signed [W-1:0] dorg [QW+1][AXES];
  logic signed [W-1:0] ddir [QW+1][AXES];
  logic        [W-1:0] dmag [QW+1][AXES];
  logic signed [W-1:0] dst  [QW+1];
  logic signed [W-1:0] dend [QW+1];
  logic       [DW-1:0] rem  [QW+1][AXES];
  logic       [QW-1:0] quo  [QW+1][AXES];

  logic signed [W-1:0] in_org [AXES];
  logic signed [W-1:0] in_dir [AXES];
  assign in_org[0] = origin_x;
  assign in_org[1] = origin_y;
  assign in_org[2] = origin_z;
  assign in_dir[0] = direction_x;
  assign in_dir[1] = direction_y;
  assign in_dir[2] = direction_z;

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dst[0]  <= interval_start;
      dend[0] <= interval_end;
      for (int a = 0; a < AXES; a++) begin
        dorg[0][a] <= in_org[a];
        ddir[0][a] <= in_dir[a];
        dmag[0][a] <= in_dir[a][W-1] ? W'(-in_dir[a]) : in_dir[a];
        rem[0][a]  <= '0;
        quo[0][a]  <= '0;
      end
    end
  end

  // one restoring step per stage; the dividend is a single one at its top bit
  for (genvar k = 0; k < QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (en) dv[k+1] <= dv[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dst[k+1]  <= dst[k];
        dend[k+1] <= dend[k];
        for (int a = 0; a < AXES; a++) begin
          dorg[k+1][a] <= dorg[k][a];
          ddir[k+1][a] <= ddir[k][a];
          dmag[k+1][a] <= dmag[k][a];
        end
      end
    end

    for (genvar a = 0; a < AXES; a++) begin : g_ax
      logic [DW-1:0] sh;
      logic          ge;
      assign sh = {rem[k][a][DW-2:0], (k == 0) ? 1'b1 : 1'b0};
      assign ge = sh >= {1'b0, dmag[k][a]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1][a] <= ge ? sh - {1'b0, dmag[k][a]} : sh;
          quo[k+1][a] <= {quo[k][a][QW-2:0], ge};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // s1: clamped signed reciprocal, plane differences kept exact
  // --------------------------------------------------------------------------
  logic                v1;
  logic signed [W-1:0] org1 [AXES];
  logic signed [W-1:0] dir1 [AXES];
  logic signed [W-1:0] st1, end1;
  logic signed [W-1:0] r1   [AXES];
  logic signed [W:0]   dlo1 [AXES];
  logic signed [W:0]   dhi1 [AXES];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= dv[QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1  <= dst[QW];
      end1 <= dend[QW];
      for (int a = 0; a < AXES; a++) begin
        logic [XW-1:0] qe;
        logic [W-1:0]  qs;
        qe = XW'(quo[QW][a]);
        qs = (qe > XW'(CMAX)) ? CMAX : qe[W-1:0];
        org1[a] <= dorg[QW][a];
        dir1[a] <= ddir[QW][a];
        r1[a]   <= ddir[QW][a][W-1] ? W'(-qs) : qs;
        dlo1[a] <= {box_lo[a][W-1], box_lo[a]} - {dorg[QW][a][W-1], dorg[QW][a]};
        dhi1[a] <= {box_hi[a][W-1], box_hi[a]} - {dorg[QW][a][W-1], dorg[QW][a]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // s2: plane distance products, slab check for zero direction components
  // --------------------------------------------------------------------------
  logic                v2;
  logic signed [W-1:0] org2 [AXES];
  logic signed [W-1:0] dir2 [AXES];
  logic signed [W-1:0] st2, end2;
  logic       [PW-1:0] plo2 [AXES];
  logic       [PW-1:0] phi2 [AXES];
  logic                nlo2 [AXES];
  logic                nhi2 [AXES];
  logic                zero2 [AXES];
  logic                in2  [AXES];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st2  <= st1;
      end2 <= end1;
      for (int a = 0; a < AXES; a++) begin
        logic [W:0]          mlo;
        logic [W:0]          mhi;
        logic [W-1:0]        mr;
        logic signed [W-1:0] sa;
        logic signed [W-1:0] sb;
        mlo = dlo1[a][W] ? (W+1)'(-dlo1[a]) : dlo1[a];
        mhi = dhi1[a][W] ? (W+1)'(-dhi1[a]) : dhi1[a];
        mr  = r1[a][W-1] ? W'(-r1[a]) : r1[a];
        sa  = (box_lo[a] < box_hi[a]) ? box_lo[a] : box_hi[a];
        sb  = (box_lo[a] < box_hi[a]) ? box_hi[a] : box_lo[a];
        org2[a]  <= org1[a];
        dir2[a]  <= dir1[a];
        plo2[a]  <= PW'(mlo) * PW'(mr);
        phi2[a]  <= PW'(mhi) * PW'(mr);
        nlo2[a]  <= dlo1[a][W] ^ r1[a][W-1];
        nhi2[a]  <= dhi1[a][W] ^ r1[a][W-1];
        zero2[a] <= (dir1[a] == '0);
        in2[a]   <= (org1[a] >= sa) && (org1[a] <= sb);
      end
    end
  end

  // --------------------------------------------------------------------------
  // s3: scaled plane distances, near and far per axis
  // --------------------------------------------------------------------------
  logic                v3;
  logic signed [W-1:0] org3 [AXES];
  logic signed [W-1:0] dir3 [AXES];
  logic signed [W-1:0] st3, end3;
  logic signed [W-1:0] near3 [AXES];
  logic signed [W-1:0] far3  [AXES];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st3  <= st2;
      end3 <= end2;
      for (int a = 0; a < AXES; a++) begin
        logic signed [W-1:0] t0;
        logic signed [W-1:0] t1;
        t0 = fix_scale(plo2[a], nlo2[a]);
        t1 = fix_scale(phi2[a], nhi2[a]);
        org3[a] <= org2[a];
        dir3[a] <= dir2[a];
        if (zero2[a]) begin
          near3[a] <= in2[a] ? CMIN : CMAX;
          far3[a]  <= in2[a] ? CMAX : CMIN;
        end else begin
          near3[a] <= (t0 < t1) ? t0 : t1;
          far3[a]  <= (t0 < t1) ? t1 : t0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // s4: entry and exit over the three axes
  // --------------------------------------------------------------------------
  logic                v4;
  logic signed [W-1:0] org4 [AXES];
  logic signed [W-1:0] dir4 [AXES];
  logic signed [W-1:0] st4, end4;
  logic signed [W-1:0] ent4, ext4;
  logic signed [W-1:0] ent_c, ext_c;

  always_comb begin
    ent_c = near3[0];
    ext_c = far3[0];
    for (int a = 1; a < AXES; a++) begin
      if (near3[a] > ent_c) ent_c = near3[a];
      if (far3[a] < ext_c) ext_c = far3[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st4  <= st3;
      end4 <= end3;
      ent4 <= ent_c;
      ext4 <= ext_c;
      for (int a = 0; a < AXES; a++) begin
        org4[a] <= org3[a];
        dir4[a] <= dir3[a];
      end
    end
  end

  // --------------------------------------------------------------------------
  // s5: hit decision, entry times direction products
  // --------------------------------------------------------------------------
  logic                v5;
  logic                hit5;
  logic signed [W-1:0] org5 [AXES];
  logic signed [W-1:0] ent5, ext5;
  logic       [EW-1:0] pe5  [AXES];
  logic                ne5  [AXES];

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit5 <= (ent4 <= ext4) && (ext4 > 0) && (ent4 > st4) && (ent4 < end4);
      ent5 <= ent4;
      ext5 <= ext4;
      for (int a = 0; a < AXES; a++) begin
        logic [W-1:0] me;
        logic [W-1:0] md;
        me = ent4[W-1] ? W'(-ent4) : ent4;
        md = dir4[a][W-1] ? W'(-dir4[a]) : dir4[a];
        org5[a] <= org4[a];
        pe5[a]  <= EW'(me) * EW'(md);
        ne5[a]  <= ent4[W-1] ^ dir4[a][W-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // s6: entry point and output register
  // --------------------------------------------------------------------------
  logic signed [W-1:0] pt6 [AXES];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v5;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit            <= hit5;
      entry_distance <= ent5;
      exit_distance  <= ext5;
      for (int a = 0; a < AXES; a++) begin
        logic signed [W-1:0] t;
        logic signed [W:0]   s;
        t = fix_scale(PW'(pe5[a]), ne5[a]);
        s = {org5[a][W-1], org5[a]} + {t[W-1], t};
        if (!hit5) pt6[a] <= '0;
        else if (s[W] != s[W-1]) pt6[a] <= s[W] ? CMIN : CMAX;
        else pt6[a] <= s[W-1:0];
      end
    end
  end

  assign point_x = pt6[0];
  assign point_y = pt6[1];
  assign point_z = pt6[2];

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_miss_point_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> point_x == '0 && point_y == '0 && point_z == '0)
    else $error("miss with non-zero entry point");

  a_hit_ordered : assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> entry_distance <= exit_distance)
    else $error("hit with entry beyond exit");

  a_hit_exit_ahead : assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> exit_distance > 0)
    else $error("hit with exit behind origin");

endmodule
